>>> rtl/assert_macros.svh
// Shared assertion macros, clocked on clk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold expr at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Hold cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Hold cons in the same cycle as ante.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/jps_pkg.sv
`default_nettype none

package jps_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int POS_W      = 8;
    localparam int Q_W        = 16;
    localparam int DZ_W       = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NORM_FRAC  = 15;
    localparam int SPAN_FLOOR = 16;

    localparam logic [Q_W:0] NORM_ONE = 17'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_POSITION   = 3'd0,
        REG_START_POSITION = 3'd1,
        REG_INVERT_AXIS    = 3'd2,
        REG_DEADZONE       = 3'd3,
        REG_SMOOTHING_GAIN = 3'd4,
        REG_MAX_STEP       = 3'd5
    } cfg_index_t;

    localparam logic [POS_W-1:0] MAX_POSITION_RST   = 8'd26;
    localparam logic [POS_W-1:0] START_POSITION_RST = 8'd13;
    localparam logic             INVERT_AXIS_RST    = 1'b1;
    localparam logic [DZ_W-1:0]  DEADZONE_RST       = 15'd2621;
    localparam logic [Q_W-1:0]   SMOOTHING_GAIN_RST = 16'd5243;
    localparam logic [Q_W-1:0]   MAX_STEP_RST       = 16'd768;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_CAL_DIV   = 11'b000_0000_0010,
        ST_CAL_SET   = 11'b000_0000_0100,
        ST_TICK_PREP = 11'b000_0000_1000,
        ST_TICK_DIV  = 11'b000_0001_0000,
        ST_TICK_NORM = 11'b000_0010_0000,
        ST_MUL_POS   = 11'b000_0100_0000,
        ST_TICK_DIFF = 11'b000_1000_0000,
        ST_MUL_STEP  = 11'b001_0000_0000,
        ST_TICK_UPD  = 11'b010_0000_0000,
        ST_FIN       = 11'b100_0000_0000
    } state_t;

endpackage

`default_nettype wire

>>> rtl/joystick_position_smoother_core.sv
// Joystick position smoother. The first CAL_COUNT samples calibrate the
// axis (min, max, sum, then center and span); every later sample is a tick
// that normalizes the deflection, applies deadzone and inversion, and,
// outside the deadzone, moves a Q8.8 target toward the matching screen
// position by a gain-scaled, step-limited amount. Each accepted sample
// yields exactly one result. The sample that ends calibration divides the
// sum by CAL_COUNT in the shared restoring divider, which runs one quotient
// bit per cycle over every bit of the sum, 8 bits wider than a sample. An
// active tick uses 15 divider steps for the normalized deflection plus the
// two passes of the shared multiplier. A saturated deflection skips the
// divider, and a deadzone tick skips the multiplier. A finished result sits
// in the output register while the next sample is accepted; a result that
// is done while an earlier one still waits there is held until the earlier
// one is taken. A new sample is accepted only when idle.
`default_nettype none
`include "assert_macros.svh"

module joystick_position_smoother_core
    import jps_pkg::*;
#(
    parameter int CAL_COUNT = 150,
    parameter int ADC_BITS  = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [POS_W-1:0]           position,
    output logic                       calibrating,
    output logic                       active,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW   = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int NW   = SW + 8;
    localparam int CNTW = $clog2(NW + 1);

    state_t state_reg, state_next;

    logic [POS_W-1:0] max_position_reg, start_position_reg;
    logic             invert_axis_reg;
    logic [DZ_W-1:0]  deadzone_reg;
    logic [Q_W-1:0]   smoothing_gain_reg, max_step_reg;

    logic [7:0]    cal_count_reg, cal_count_next;
    logic [SW-1:0] sample_min_reg, sample_min_next;
    logic [SW-1:0] sample_max_reg, sample_max_next;
    logic [NW-1:0] sample_sum_reg, sample_sum_next;
    logic [SW-1:0] center_reg, center_next;
    logic [SW-1:0] span_reg, span_next;
    logic [Q_W-1:0] target_reg, target_next;
    logic          out_valid_reg, out_valid_next;

    logic [SW-1:0]   sample_reg, sample_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   numer_reg, numer_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic            sat_reg, sat_next;
    logic            act_reg, act_next;
    logic            cal_item_reg, cal_item_next;
    logic [Q_W:0]    pos01_reg, pos01_next;
    logic [Q_W-1:0]  dmag_reg, dmag_next;
    logic            dneg_reg, dneg_next;
    logic [2*Q_W:0]  prod_reg, prod_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic            calibrating_reg, calibrating_next;
    logic            active_reg, active_next;

    logic [SW-1:0]  s_in;
    logic [SW:0]    div_try;
    logic [SW-1:0]  divisor;
    logic           div_ge;
    logic [SW-1:0]  div_rem;
    logic [NW-1:0]  div_numer;
    logic [Q_W:0]   mul_a;
    logic [Q_W-1:0] mul_b;
    logic [2*Q_W:0] mul_prod;
    logic [Q_W-1:0] nmag;
    logic           neg_eff;
    logic [SW-1:0]  mag;
    logic [SW-1:0]  span_raw;
    logic [Q_W-1:0] desired;
    logic [Q_W-1:0] smag;
    logic [Q_W:0]   up_sum;
    logic [8:0]     rnd;
    logic [POS_W-1:0] rnd_pos;

    assign s_in      = sample[SW-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign calibrating = calibrating_reg;
    assign active      = active_reg;

    // shared restoring divider step
    assign divisor   = (state_reg == ST_CAL_DIV) ? SW'(CAL_COUNT) : span_reg;
    assign div_try   = {rem_reg, numer_reg[NW-1]};
    assign div_ge    = (div_try >= {1'b0, divisor});
    assign div_rem   = div_ge ? SW'(div_try - {1'b0, divisor}) : div_try[SW-1:0];
    assign div_numer = {numer_reg[NW-2:0], div_ge};

    // shared multiplier
    always_comb
    begin
        if (state_reg == ST_MUL_POS)
        begin
            mul_a = pos01_reg;
            mul_b = {{(Q_W-POS_W){1'b0}}, max_position_reg};
        end
        else
        begin
            mul_a = {1'b0, dmag_reg};
            mul_b = smoothing_gain_reg;
        end
    end
    assign mul_prod = {{Q_W{1'b0}}, mul_a} * {{(Q_W+1){1'b0}}, mul_b};

    assign mag      = (sample_reg < center_reg) ? (center_reg - sample_reg)
                                                : (sample_reg - center_reg);
    assign nmag     = sat_reg ? NORM_ONE[Q_W-1:0]
                              : {{(Q_W-NORM_FRAC){1'b0}}, numer_reg[NORM_FRAC-1:0]};
    assign neg_eff  = (neg_reg ^ invert_axis_reg) && (nmag != '0);
    assign span_raw = (sample_max_reg > numer_reg[SW-1:0])
                    ? (sample_max_reg - numer_reg[SW-1:0])
                    : (numer_reg[SW-1:0] - sample_min_reg);
    assign desired  = prod_reg[Q_W+7:8];
    assign smag     = (prod_reg[2*Q_W-1:Q_W] > max_step_reg) ? max_step_reg
                                                            : prod_reg[2*Q_W-1:Q_W];
    assign up_sum   = {1'b0, target_reg} + {1'b0, smag};
    assign rnd      = 9'(({1'b0, target_reg} + 17'd128) >> 8);
    assign rnd_pos  = (rnd > {1'b0, max_position_reg}) ? max_position_reg : rnd[POS_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        cal_count_next   = cal_count_reg;
        sample_min_next  = sample_min_reg;
        sample_max_next  = sample_max_reg;
        sample_sum_next  = sample_sum_reg;
        center_next      = center_reg;
        span_next        = span_reg;
        target_next      = target_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        sample_next      = sample_reg;
        rem_next         = rem_reg;
        numer_next       = numer_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        sat_next         = sat_reg;
        act_next         = act_reg;
        cal_item_next    = cal_item_reg;
        pos01_next       = pos01_reg;
        dmag_next        = dmag_reg;
        dneg_next        = dneg_reg;
        prod_next        = prod_reg;
        position_next    = position_reg;
        calibrating_next = calibrating_reg;
        active_next      = active_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = s_in;
                    act_next    = 1'b0;
                    if (cal_count_reg < 8'(CAL_COUNT))
                    begin
                        cal_item_next   = 1'b1;
                        sample_min_next = (s_in < sample_min_reg) ? s_in : sample_min_reg;
                        sample_max_next = (s_in > sample_max_reg) ? s_in : sample_max_reg;
                        sample_sum_next = sample_sum_reg + NW'(s_in);
                        cal_count_next  = cal_count_reg + 8'd1;
                        if (cal_count_reg == 8'(CAL_COUNT - 1))
                        begin
                            rem_next   = '0;
                            numer_next = sample_sum_next;
                            cnt_next   = CNTW'(NW);
                            state_next = ST_CAL_DIV;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    else
                    begin
                        cal_item_next = 1'b0;
                        state_next    = ST_TICK_PREP;
                    end
                end
            end
            ST_CAL_DIV:
            begin
                rem_next   = div_rem;
                numer_next = div_numer;
                cnt_next   = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_CAL_SET;
                end
            end
            ST_CAL_SET:
            begin
                center_next = numer_reg[SW-1:0];
                span_next   = (span_raw < SW'(SPAN_FLOOR)) ? SW'(SPAN_FLOOR) : span_raw;
                target_next = {start_position_reg, 8'd0};
                state_next  = ST_FIN;
            end
            ST_TICK_PREP:
            begin
                neg_next   = (sample_reg < center_reg);
                sat_next   = (mag >= span_reg);
                rem_next   = mag;
                numer_next = '0;
                cnt_next   = CNTW'(NORM_FRAC);
                state_next = (mag >= span_reg) ? ST_TICK_NORM : ST_TICK_DIV;
            end
            ST_TICK_DIV:
            begin
                rem_next   = div_rem;
                numer_next = div_numer;
                cnt_next   = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_TICK_NORM;
                end
            end
            ST_TICK_NORM:
            begin
                act_next   = (nmag > {1'b0, deadzone_reg});
                pos01_next = neg_eff ? (NORM_ONE - {1'b0, nmag}) : (NORM_ONE + {1'b0, nmag});
                state_next = (nmag > {1'b0, deadzone_reg}) ? ST_MUL_POS : ST_FIN;
            end
            ST_MUL_POS:
            begin
                prod_next  = mul_prod;
                state_next = ST_TICK_DIFF;
            end
            ST_TICK_DIFF:
            begin
                dneg_next  = (desired < target_reg);
                dmag_next  = (desired < target_reg) ? (target_reg - desired)
                                                    : (desired - target_reg);
                state_next = ST_MUL_STEP;
            end
            ST_MUL_STEP:
            begin
                prod_next  = mul_prod;
                state_next = ST_TICK_UPD;
            end
            ST_TICK_UPD:
            begin
                if (dneg_reg)
                begin
                    target_next = (smag > target_reg) ? '0 : (target_reg - smag);
                end
                else
                begin
                    target_next = up_sum[Q_W] ? {Q_W{1'b1}} : up_sum[Q_W-1:0];
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    position_next    = rnd_pos;
                    calibrating_next = cal_item_reg;
                    active_next      = act_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            max_position_reg   <= MAX_POSITION_RST;
            start_position_reg <= START_POSITION_RST;
            invert_axis_reg    <= INVERT_AXIS_RST;
            deadzone_reg       <= DEADZONE_RST;
            smoothing_gain_reg <= SMOOTHING_GAIN_RST;
            max_step_reg       <= MAX_STEP_RST;
            cal_count_reg      <= '0;
            sample_min_reg     <= '1;
            sample_max_reg     <= '0;
            sample_sum_reg     <= '0;
            center_reg         <= '0;
            span_reg           <= SW'(SPAN_FLOOR);
            target_reg         <= {START_POSITION_RST, 8'd0};
            out_valid_reg      <= 1'b0;
            cnt_reg            <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cal_count_reg  <= cal_count_next;
            sample_min_reg <= sample_min_next;
            sample_max_reg <= sample_max_next;
            sample_sum_reg <= sample_sum_next;
            center_reg     <= center_next;
            span_reg       <= span_next;
            target_reg     <= target_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_POSITION:   max_position_reg   <= cfg_data[POS_W-1:0];
                    REG_START_POSITION: start_position_reg <= cfg_data[POS_W-1:0];
                    REG_INVERT_AXIS:    invert_axis_reg    <= cfg_data[0];
                    REG_DEADZONE:       deadzone_reg       <= cfg_data[DZ_W-1:0];
                    REG_SMOOTHING_GAIN: smoothing_gain_reg <= cfg_data;
                    REG_MAX_STEP:       max_step_reg       <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        rem_reg         <= rem_next;
        numer_reg       <= numer_next;
        neg_reg         <= neg_next;
        sat_reg         <= sat_next;
        act_reg         <= act_next;
        cal_item_reg    <= cal_item_next;
        pos01_reg       <= pos01_next;
        dmag_reg        <= dmag_next;
        dneg_reg        <= dneg_next;
        prod_reg        <= prod_next;
        position_reg    <= position_next;
        calibrating_reg <= calibrating_next;
        active_reg      <= active_next;
    end

    `ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready, "ready after request")
    `ASSERT_ALWAYS(a_span_floor, span_reg >= SW'(SPAN_FLOOR), "span below floor")
    `ASSERT_IMPL(a_cal_not_active, out_valid && calibrating, !active, "active on calibration")
    `ASSERT_IMPL(a_cal_set_count, state_reg == ST_CAL_SET, cal_count_reg == 8'(CAL_COUNT),
                 "calibration ended early")

endmodule

`default_nettype wire
